[sv/ale_pkg.sv]
package ale_pkg;

    localparam int DEPTH    = 32;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int CMD_W    = 3;
    localparam int STAT_W   = 3;
    localparam int POS_W    = 6;
    localparam int VAL_W    = 32;
    localparam int CMP_W    = ((IDX_W + 2 > POS_W) ? IDX_W + 2 : POS_W) + 1;
    localparam int TDATA_W  = ((POS_W + VAL_W + 7) / 8) * 8;
    localparam int TUSER_W  = 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 3'd0,
        CMD_APPEND = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_DELETE = 3'd3,
        CMD_FIND   = 3'd4,
        CMD_SORT   = 3'd5,
        CMD_LIST   = 3'd6
    } cmd_e_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE     = 3'd0,
        ST_BADPOS   = 3'd1,
        ST_FULL     = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_MATCH    = 3'd4,
        ST_ELEMENT  = 3'd5
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_REPLY,
        S_INS_RD,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_FIND_RD,
        S_FIND_CMP,
        S_FIND_END,
        S_SORT_LD,
        S_SORT_A,
        S_SORT_RD,
        S_SORT_CMP,
        S_SORT_WB,
        S_LIST_RD,
        S_LIST_EMIT
    } state_t;

    typedef enum logic [1:0] {CNT_HOLD, CNT_CLR, CNT_INC, CNT_DEC} cnt_op_t;
    typedef enum logic [2:0] {I_HOLD, I_ZERO, I_CNT, I_POSM1, I_INC, I_DEC} i_op_t;
    typedef enum logic [1:0] {J_HOLD, J_NEXT_I, J_INC} j_op_t;
    typedef enum logic [1:0] {RD_I, RD_I_M1, RD_I_P1, RD_J} rd_sel_t;
    typedef enum logic [1:0] {WA_I, WA_J, WA_CNT, WA_POSM1} wa_sel_t;
    typedef enum logic [1:0] {WD_VAL, WD_RDATA, WD_AREG} wd_sel_t;
    typedef enum logic [1:0] {OP_ZERO, OP_PEND, OP_I1} op_sel_t;

    typedef struct packed {
        logic    capture;
        cnt_op_t cnt_op;
        i_op_t   i_op;
        j_op_t   j_op;
        rd_sel_t rd_sel;
        logic    wr_en;
        wa_sel_t wa_sel;
        wd_sel_t wd_sel;
        logic    a_load;
        logic    pend_clr;
        logic    pend_set;
        logic    out_push;
        status_t out_status;
        op_sel_t out_pos_sel;
        logic    out_val_rdata;
        logic    out_last;
    } ctrl_cmd_t;

    typedef struct packed {
        cmd_e_t cmd;
        logic   pos_bad;
        logic   full;
        logic   cnt_zero;
        logic   cnt_le1;
        logic   ins_more;
        logic   i_next_lt_cnt;
        logic   i2_lt_cnt;
        logic   j_next_lt_cnt;
        logic   match;
        logic   greater;
        logic   pend;
        logic   out_free;
    } dp_stat_t;

endpackage

[sv/ale_ram.sv]
module ale_ram #(
    parameter int DATA_W = 32,
    parameter int WORDS  = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(WORDS)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic [$clog2(WORDS)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [WORDS];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/ale_dp.sv]
module ale_dp import ale_pkg::*; (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ctrl_cmd_t               cmd,
    output dp_stat_t                stat,
    input  cmd_e_t                  in_cmd,
    input  logic [POS_W-1:0]        in_position,
    input  logic signed [VAL_W-1:0] in_value,
    output logic                    out_valid,
    input  logic                    out_ready,
    output status_t                 out_status,
    output logic [POS_W-1:0]        out_position,
    output logic signed [VAL_W-1:0] out_value,
    output logic                    out_last
);

    cmd_e_t                  cmd_reg, cmd_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic signed [VAL_W-1:0] val_reg, val_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [IDX_W-1:0]        i_reg, i_next;
    logic [IDX_W-1:0]        j_reg, j_next;
    logic signed [VAL_W-1:0] a_reg, a_next;
    logic                    pend_reg, pend_next;
    logic [POS_W-1:0]        pend_pos_reg, pend_pos_next;
    logic                    out_valid_reg, out_valid_next;
    status_t                 out_status_reg, out_status_next;
    logic [POS_W-1:0]        out_pos_reg, out_pos_next;
    logic signed [VAL_W-1:0] out_val_reg, out_val_next;
    logic                    out_last_reg, out_last_next;

    logic [IDX_W-1:0]        rd_addr;
    logic [IDX_W-1:0]        wr_addr;
    logic signed [VAL_W-1:0] wr_data;
    logic signed [VAL_W-1:0] rd_data;
    logic [IDX_W-1:0]        posm1;
    logic [CMP_W-1:0]        i_wide;
    logic [CMP_W-1:0]        j_wide;
    logic [CMP_W-1:0]        cnt_wide;
    logic [CMP_W-1:0]        pos_wide;
    logic [POS_W-1:0]        i_plus1_pos;
    logic                    out_free;

    ale_ram #(
        .DATA_W (VAL_W),
        .WORDS  (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign posm1       = IDX_W'(pos_reg - POS_W'(1));
    assign i_wide      = CMP_W'(i_reg);
    assign j_wide      = CMP_W'(j_reg);
    assign cnt_wide    = CMP_W'(cnt_reg);
    assign pos_wide    = CMP_W'(pos_reg);
    assign i_plus1_pos = POS_W'(i_wide + CMP_W'(1));
    assign out_free    = !out_valid_reg || out_ready;

    // ram addressing
    always_comb
    begin
        case (cmd.rd_sel)
            RD_I:    rd_addr = i_reg;
            RD_I_M1: rd_addr = i_reg - IDX_W'(1);
            RD_I_P1: rd_addr = i_reg + IDX_W'(1);
            RD_J:    rd_addr = j_reg;
            default: rd_addr = i_reg;
        endcase
        case (cmd.wa_sel)
            WA_I:     wr_addr = i_reg;
            WA_J:     wr_addr = j_reg;
            WA_CNT:   wr_addr = IDX_W'(cnt_reg);
            WA_POSM1: wr_addr = posm1;
            default:  wr_addr = i_reg;
        endcase
        case (cmd.wd_sel)
            WD_VAL:   wr_data = val_reg;
            WD_RDATA: wr_data = rd_data;
            WD_AREG:  wr_data = a_reg;
            default:  wr_data = val_reg;
        endcase
    end

    // status towards the controller
    always_comb
    begin
        stat.cmd           = cmd_reg;
        stat.pos_bad       = (pos_reg == '0) || (pos_wide > cnt_wide);
        stat.full          = (cnt_reg == CNT_W'(DEPTH));
        stat.cnt_zero      = (cnt_reg == '0);
        stat.cnt_le1       = (cnt_reg <= CNT_W'(1));
        stat.ins_more      = (i_wide >= pos_wide);
        stat.i_next_lt_cnt = ((i_wide + CMP_W'(1)) < cnt_wide);
        stat.i2_lt_cnt     = ((i_wide + CMP_W'(2)) < cnt_wide);
        stat.j_next_lt_cnt = ((j_wide + CMP_W'(1)) < cnt_wide);
        stat.match         = (rd_data == val_reg);
        stat.greater       = (a_reg > rd_data);
        stat.pend          = pend_reg;
        stat.out_free      = out_free;
    end

    // next values
    always_comb
    begin
        cmd_next        = cmd_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        cnt_next        = cnt_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        a_next          = a_reg;
        pend_next       = pend_reg;
        pend_pos_next   = pend_pos_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_pos_next    = out_pos_reg;
        out_val_next    = out_val_reg;
        out_last_next   = out_last_reg;

        if (cmd.capture)
        begin
            cmd_next = in_cmd;
            pos_next = in_position;
            val_next = in_value;
        end

        case (cmd.cnt_op)
            CNT_HOLD: cnt_next = cnt_reg;
            CNT_CLR:  cnt_next = '0;
            CNT_INC:  cnt_next = cnt_reg + CNT_W'(1);
            CNT_DEC:  cnt_next = cnt_reg - CNT_W'(1);
            default:  cnt_next = cnt_reg;
        endcase

        case (cmd.i_op)
            I_HOLD:  i_next = i_reg;
            I_ZERO:  i_next = '0;
            I_CNT:   i_next = IDX_W'(cnt_reg);
            I_POSM1: i_next = posm1;
            I_INC:   i_next = i_reg + IDX_W'(1);
            I_DEC:   i_next = i_reg - IDX_W'(1);
            default: i_next = i_reg;
        endcase

        case (cmd.j_op)
            J_HOLD:   j_next = j_reg;
            J_NEXT_I: j_next = i_reg + IDX_W'(1);
            J_INC:    j_next = j_reg + IDX_W'(1);
            default:  j_next = j_reg;
        endcase

        if (cmd.a_load)
        begin
            a_next = rd_data;
        end

        if (cmd.pend_clr)
        begin
            pend_next = 1'b0;
        end
        else if (cmd.pend_set)
        begin
            pend_next     = 1'b1;
            pend_pos_next = i_plus1_pos;
        end

        if (cmd.out_push)
        begin
            out_valid_next  = 1'b1;
            out_status_next = cmd.out_status;
            out_last_next   = cmd.out_last;
            out_val_next    = cmd.out_val_rdata ? rd_data : '0;
            case (cmd.out_pos_sel)
                OP_ZERO: out_pos_next = '0;
                OP_PEND: out_pos_next = pend_pos_reg;
                OP_I1:   out_pos_next = i_plus1_pos;
                default: out_pos_next = '0;
            endcase
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        i_reg          <= i_next;
        j_reg          <= j_next;
        a_reg          <= a_next;
        pend_pos_reg   <= pend_pos_next;
        out_status_reg <= out_status_next;
        out_pos_reg    <= out_pos_next;
        out_val_reg    <= out_val_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_status   = out_status_reg;
    assign out_position = out_pos_reg;
    assign out_value    = out_val_reg;
    assign out_last     = out_last_reg;

endmodule

[sv/ale_ctrl.sv]
module ale_ctrl import ale_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    state_t  state_reg, state_next;
    status_t reply_reg, reply_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            reply_reg <= ST_DONE;
        end
        else
        begin
            state_reg <= state_next;
            reply_reg <= reply_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        reply_next = reply_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.rd_sel = RD_I;

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end

            S_DECODE:
            begin
                reply_next = ST_DONE;
                state_next = S_REPLY;
                case (stat.cmd)
                    CMD_CLEAR:
                    begin
                        cmd.cnt_op = CNT_CLR;
                    end
                    CMD_APPEND:
                    begin
                        if (stat.full)
                        begin
                            reply_next = ST_FULL;
                        end
                        else
                        begin
                            cmd.wr_en  = 1'b1;
                            cmd.wa_sel = WA_CNT;
                            cmd.wd_sel = WD_VAL;
                            cmd.cnt_op = CNT_INC;
                        end
                    end
                    CMD_INSERT:
                    begin
                        if (stat.pos_bad)
                        begin
                            reply_next = ST_BADPOS;
                        end
                        else if (stat.full)
                        begin
                            reply_next = ST_FULL;
                        end
                        else
                        begin
                            cmd.i_op   = I_CNT;
                            state_next = S_INS_RD;
                        end
                    end
                    CMD_DELETE:
                    begin
                        if (stat.pos_bad)
                        begin
                            reply_next = ST_BADPOS;
                        end
                        else
                        begin
                            cmd.i_op   = I_POSM1;
                            state_next = S_DEL_RD;
                        end
                    end
                    CMD_FIND:
                    begin
                        cmd.pend_clr = 1'b1;
                        if (stat.cnt_zero)
                        begin
                            reply_next = ST_NOTFOUND;
                        end
                        else
                        begin
                            cmd.i_op   = I_ZERO;
                            state_next = S_FIND_RD;
                        end
                    end
                    CMD_SORT:
                    begin
                        if (!stat.cnt_le1)
                        begin
                            cmd.i_op   = I_ZERO;
                            state_next = S_SORT_LD;
                        end
                    end
                    CMD_LIST:
                    begin
                        if (!stat.cnt_zero)
                        begin
                            cmd.i_op   = I_ZERO;
                            state_next = S_LIST_RD;
                        end
                    end
                    default:
                    begin
                        // unused code: no result
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_REPLY:
            begin
                if (stat.out_free)
                begin
                    cmd.out_push    = 1'b1;
                    cmd.out_status  = reply_reg;
                    cmd.out_pos_sel = OP_ZERO;
                    cmd.out_last    = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            // shift up from the tail, then drop the new value in
            S_INS_RD:
            begin
                if (stat.ins_more)
                begin
                    cmd.rd_sel = RD_I_M1;
                    state_next = S_INS_WR;
                end
                else
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wa_sel = WA_POSM1;
                    cmd.wd_sel = WD_VAL;
                    cmd.cnt_op = CNT_INC;
                    reply_next = ST_DONE;
                    state_next = S_REPLY;
                end
            end

            S_INS_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wa_sel = WA_I;
                cmd.wd_sel = WD_RDATA;
                cmd.i_op   = I_DEC;
                state_next = S_INS_RD;
            end

            S_DEL_RD:
            begin
                if (stat.i_next_lt_cnt)
                begin
                    cmd.rd_sel = RD_I_P1;
                    state_next = S_DEL_WR;
                end
                else
                begin
                    cmd.cnt_op = CNT_DEC;
                    reply_next = ST_DONE;
                    state_next = S_REPLY;
                end
            end

            S_DEL_WR:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wa_sel = WA_I;
                cmd.wd_sel = WD_RDATA;
                cmd.i_op   = I_INC;
                state_next = S_DEL_RD;
            end

            S_FIND_RD:
            begin
                state_next = S_FIND_CMP;
            end

            // one match is held back so the final one can carry last
            S_FIND_CMP:
            begin
                if (!(stat.match && stat.pend && !stat.out_free))
                begin
                    if (stat.match)
                    begin
                        cmd.pend_set = 1'b1;
                        if (stat.pend)
                        begin
                            cmd.out_push    = 1'b1;
                            cmd.out_status  = ST_MATCH;
                            cmd.out_pos_sel = OP_PEND;
                        end
                    end
                    if (stat.i_next_lt_cnt)
                    begin
                        cmd.i_op   = I_INC;
                        state_next = S_FIND_RD;
                    end
                    else
                    begin
                        state_next = S_FIND_END;
                    end
                end
            end

            S_FIND_END:
            begin
                if (stat.out_free)
                begin
                    cmd.out_push = 1'b1;
                    cmd.out_last = 1'b1;
                    if (stat.pend)
                    begin
                        cmd.out_status  = ST_MATCH;
                        cmd.out_pos_sel = OP_PEND;
                    end
                    else
                    begin
                        cmd.out_status  = ST_NOTFOUND;
                        cmd.out_pos_sel = OP_ZERO;
                    end
                    state_next = S_IDLE;
                end
            end

            // exchange sort, element i kept in the a register
            S_SORT_LD:
            begin
                state_next = S_SORT_A;
            end

            S_SORT_A:
            begin
                cmd.a_load = 1'b1;
                cmd.j_op   = J_NEXT_I;
                state_next = S_SORT_RD;
            end

            S_SORT_RD:
            begin
                cmd.rd_sel = RD_J;
                state_next = S_SORT_CMP;
            end

            S_SORT_CMP:
            begin
                cmd.rd_sel = RD_J;
                if (stat.greater)
                begin
                    cmd.wr_en  = 1'b1;
                    cmd.wa_sel = WA_J;
                    cmd.wd_sel = WD_AREG;
                    cmd.a_load = 1'b1;
                end
                if (stat.j_next_lt_cnt)
                begin
                    cmd.j_op   = J_INC;
                    state_next = S_SORT_RD;
                end
                else
                begin
                    state_next = S_SORT_WB;
                end
            end

            S_SORT_WB:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wa_sel = WA_I;
                cmd.wd_sel = WD_AREG;
                if (stat.i2_lt_cnt)
                begin
                    cmd.i_op   = I_INC;
                    state_next = S_SORT_LD;
                end
                else
                begin
                    reply_next = ST_DONE;
                    state_next = S_REPLY;
                end
            end

            S_LIST_RD:
            begin
                state_next = S_LIST_EMIT;
            end

            S_LIST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_push      = 1'b1;
                    cmd.out_status    = ST_ELEMENT;
                    cmd.out_pos_sel   = OP_I1;
                    cmd.out_val_rdata = 1'b1;
                    cmd.out_last      = !stat.i_next_lt_cnt;
                    if (stat.i_next_lt_cnt)
                    begin
                        cmd.i_op   = I_INC;
                        state_next = S_LIST_RD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[sv/array_list_engine.sv]
// Ordered list of up to 32 signed 32-bit values. One command item goes in
// (clear, append, insert, delete, find, sort, list) and one or more result
// items come out, the final one with tlast set; an unused command code gives
// no result. The block works on one command at a time: a new item is taken
// once the previous command has finished, while its last result may still
// sit in the output register. The list lives in a single-port-read RAM, so
// every element step takes a read state followed by a write, compare or emit
// state, and steps that emit a result wait while the output is stalled.
module array_list_engine import ale_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,   // position[5:0], value[37:6]
    input  logic [TUSER_W-1:0] s_tuser,   // cmd[2:0]
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // position_res[5:0], value_res[37:6]
    output logic [TUSER_W-1:0] m_tuser,   // status[2:0]
    output logic               m_tlast
);

    ctrl_cmd_t               cmd;
    dp_stat_t                stat;
    status_t                 out_status;
    logic [POS_W-1:0]        out_position;
    logic signed [VAL_W-1:0] out_value;

    ale_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ale_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .in_cmd       (cmd_e_t'(s_tuser[CMD_W-1:0])),
        .in_position  (s_tdata[POS_W-1:0]),
        .in_value     (s_tdata[POS_W+VAL_W-1:POS_W]),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_status   (out_status),
        .out_position (out_position),
        .out_value    (out_value),
        .out_last     (m_tlast)
    );

    assign m_tdata = {{(TDATA_W-POS_W-VAL_W){1'b0}}, out_value, out_position};
    assign m_tuser = {{(TUSER_W-STAT_W){1'b0}}, out_status};

endmodule
